[rtl/tsag_pkg.sv]
// ----------------------------------------------------------------------------
// tsag_pkg
// Types and constants shared by the tensor slice address generator.
// ----------------------------------------------------------------------------
package tsag_pkg;

  localparam int unsigned MAX_DIMS   = 4;
  localparam int unsigned DIM_W      = 2;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned RANK_W     = 3;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned ADDR_W     = 40;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic {
    CMD_SET_BOUND = 1'b0,
    CMD_NEXT      = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_RANGE = 2'd1,
    ST_BAD_DIM      = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANK      = 3'd0,
    REG_SIZE_DIM0 = 3'd1,
    REG_SIZE_DIM1 = 3'd2,
    REG_SIZE_DIM2 = 3'd3,
    REG_SIZE_DIM3 = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STRIDE,
    S_SUM,
    S_EMIT
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [DIM_W-1:0] dim_select;
    logic [IDX_W-1:0] range_start;
    logic [IDX_W-1:0] range_end;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] source_index;
    logic [LEN_W-1:0]  slice_length;
    logic              last_element;
    status_e           status;
  } out_word_t;

  typedef struct packed {
    logic load_item;
    logic stride_step;
    logic bound_commit;
    logic sum_step;
    logic walk_finish;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_next;
    logic in_bound_ok;
    logic stride_done;
    logic sum_done;
  } dp_sts_t;

endpackage

[rtl/tsag_in_if.sv]
// ----------------------------------------------------------------------------
// tsag_in_if
// Input channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface tsag_in_if;
  import tsag_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/tsag_out_if.sv]
// ----------------------------------------------------------------------------
// tsag_out_if
// Output channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface tsag_out_if;
  import tsag_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/tsag_ctrl.sv]
// ----------------------------------------------------------------------------
// tsag_ctrl
// Sequencer: accepts a word, steps the stride or index loop, emits a result.
// ----------------------------------------------------------------------------
module tsag_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tsag_pkg::dp_sts_t sts_i,
  output tsag_pkg::ctrl_t   ctrl_o
);
  import tsag_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_next) begin
            state_d = S_SUM;
          end else if (sts_i.in_bound_ok) begin
            state_d = S_STRIDE;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_STRIDE: begin
        if (sts_i.stride_done) state_d = S_EMIT;
      end
      S_SUM: begin
        if (sts_i.sum_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o              = '0;
    ctrl_o.load_item    = (state_q == S_IDLE) && in_valid_i;
    ctrl_o.stride_step  = (state_q == S_STRIDE) && !sts_i.stride_done;
    ctrl_o.bound_commit = (state_q == S_STRIDE) && sts_i.stride_done;
    ctrl_o.sum_step     = (state_q == S_SUM) && !sts_i.sum_done;
    ctrl_o.walk_finish  = (state_q == S_SUM) && sts_i.sum_done;
    ctrl_o.out_load     = (state_q == S_EMIT) && slot_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/tsag_datapath.sv]
// ----------------------------------------------------------------------------
// tsag_datapath
// Configuration, bound and walk state, stride multiplier, index accumulator.
// ----------------------------------------------------------------------------
module tsag_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tsag_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tsag_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  tsag_pkg::in_word_t                  in_data_i,
  input  tsag_pkg::ctrl_t                     ctrl_i,
  output tsag_pkg::dp_sts_t                   sts_o,
  output tsag_pkg::out_word_t                 out_data_o
);
  import tsag_pkg::*;

  logic [RANK_W-1:0] rank_q;
  logic [SIZE_W-1:0] size_q [MAX_DIMS];

  logic [IDX_W-1:0]  first_q [MAX_DIMS];
  logic [IDX_W-1:0]  last_q  [MAX_DIMS];
  logic [IDX_W-1:0]  pos_q   [MAX_DIMS];
  logic [IDX_W-1:0]  pos_d   [MAX_DIMS];
  logic [ADDR_W-1:0] stride_q [MAX_DIMS];
  logic              started_q;

  logic [DIM_W-1:0]  dim_q;
  logic [IDX_W-1:0]  start_q, end_q;
  logic [LEN_W-1:0]  len_q, len_d;
  status_e           status_q, status_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] prod_q;
  logic [ADDR_W-1:0] acc_q;
  logic              last_flag_q;
  out_word_t         out_q;

  logic [RANK_W-1:0]       rank_eff;
  logic [SIZE_W-1:0]       in_size;
  logic                    dim_ok, plain, bad;
  logic [LEN_W:0]          len_raw;
  logic [MAX_DIMS-1:0]     wrap, at_last, in_rank;
  logic [IDX_W-1:0]        first_pos [MAX_DIMS];
  logic [IDX_W-1:0]        next_pos  [MAX_DIMS];
  logic                    carry, all_last;
  logic [ADDR_W+SIZE_W-1:0] prod_ext;
  logic [ADDR_W+IDX_W-1:0]  term;

  assign rank_eff = (rank_q > RANK_W'(MAX_DIMS)) ? RANK_W'(MAX_DIMS) : rank_q;

  // set-bound check of the incoming word
  assign in_size = size_q[in_data_i.dim_select];
  assign dim_ok  = (RANK_W'(in_data_i.dim_select) < rank_eff);
  assign plain   = (in_data_i.range_start <= in_data_i.range_end);
  assign bad     = plain ? ({1'b0, in_data_i.range_end} >= in_size)
                         : ({1'b0, in_data_i.range_start} >= in_size);

  always_comb begin
    if (plain) begin
      len_raw = {2'b00, in_data_i.range_end} - {2'b00, in_data_i.range_start}
              + (LEN_W+1)'(1);
    end else begin
      len_raw = {2'b00, in_data_i.range_end} + (LEN_W+1)'(1) + {1'b0, in_size}
              - {2'b00, in_data_i.range_start};
    end
  end

  always_comb begin
    len_d    = '0;
    status_d = ST_OK;
    if (in_data_i.cmd == CMD_SET_BOUND) begin
      if (!dim_ok) begin
        status_d = ST_BAD_DIM;
      end else if (bad) begin
        status_d = ST_OUT_OF_RANGE;
      end else begin
        len_d = len_raw[LEN_W-1:0];
      end
    end
  end

  assign sts_o.in_next     = (in_data_i.cmd == CMD_NEXT);
  assign sts_o.in_bound_ok = dim_ok && !bad;
  assign sts_o.stride_done = (cnt_q == CNT_W'(dim_q));
  assign sts_o.sum_done    = (cnt_q == CNT_W'(rank_eff));

  // per-dimension walk terms
  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      in_rank[k]   = (RANK_W'(k) < rank_eff);
      wrap[k]      = (first_q[k] > last_q[k]);
      first_pos[k] = wrap[k] ? '0 : first_q[k];
      at_last[k]   = wrap[k] ? (({1'b0, pos_q[k]} + SIZE_W'(1)) >= size_q[k])
                             : (pos_q[k] >= last_q[k]);
      next_pos[k]  = (wrap[k] && (pos_q[k] == last_q[k])) ? first_q[k]
                                                          : pos_q[k] + IDX_W'(1);
    end
  end

  always_comb begin
    carry = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      pos_d[k] = pos_q[k];
      if (in_rank[k]) begin
        if (!started_q) begin
          pos_d[k] = first_pos[k];
        end else if (carry) begin
          if (!at_last[k]) begin
            pos_d[k] = next_pos[k];
            carry    = 1'b0;
          end else begin
            pos_d[k] = first_pos[k];
          end
        end
      end
    end
  end

  assign all_last = &(at_last | ~in_rank);
  assign prod_ext = prod_q * size_q[cnt_q[DIM_W-1:0]];
  assign term     = pos_q[cnt_q[DIM_W-1:0]] * stride_q[cnt_q[DIM_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RANK_W'(1);
      for (int k = 0; k < MAX_DIMS; k++) begin
        size_q[k] <= SIZE_W'(1);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RANK:      rank_q    <= cfg_wdata_i[RANK_W-1:0];
        REG_SIZE_DIM0: size_q[0] <= cfg_wdata_i;
        REG_SIZE_DIM1: size_q[1] <= cfg_wdata_i;
        REG_SIZE_DIM2: size_q[2] <= cfg_wdata_i;
        REG_SIZE_DIM3: size_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        first_q[k] <= '0;
        last_q[k]  <= '0;
        pos_q[k]   <= '0;
      end
    end else begin
      if (ctrl_i.load_item && (in_data_i.cmd == CMD_NEXT)) begin
        started_q <= 1'b1;
        for (int k = 0; k < MAX_DIMS; k++) begin
          pos_q[k] <= pos_d[k];
        end
      end
      if (ctrl_i.bound_commit) begin
        first_q[dim_q] <= start_q;
        last_q[dim_q]  <= end_q;
        started_q      <= 1'b0;
      end
      if (ctrl_i.walk_finish && all_last) begin
        started_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.bound_commit) begin
      stride_q[dim_q] <= prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load_item) begin
      cnt_q <= '0;
    end else if (ctrl_i.stride_step || ctrl_i.sum_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      dim_q       <= in_data_i.dim_select;
      start_q     <= in_data_i.range_start;
      end_q       <= in_data_i.range_end;
      len_q       <= len_d;
      status_q    <= status_d;
      prod_q      <= ADDR_W'(1);
      acc_q       <= '0;
      last_flag_q <= 1'b0;
    end else begin
      if (ctrl_i.stride_step) prod_q <= prod_ext[ADDR_W-1:0];
      if (ctrl_i.sum_step)    acc_q  <= acc_q + term[ADDR_W-1:0];
      if (ctrl_i.walk_finish) last_flag_q <= all_last;
    end
    if (ctrl_i.out_load) begin
      out_q.source_index <= acc_q;
      out_q.slice_length <= len_q;
      out_q.last_element <= last_flag_q;
      out_q.status       <= status_q;
    end
  end

  assign out_data_o = out_q;

endmodule

[rtl/tensor_slice_address_generator_core.sv]
// ----------------------------------------------------------------------------
// tensor_slice_address_generator_core
// Walks a tensor slice and returns flat source indices, dimension 0 innermost.
// ----------------------------------------------------------------------------
// Input words are handled one at a time. For a next word the index is summed
// one dimension per cycle through a single position-by-stride multiplier. For
// a successful set-bound word the stride is built one dimension size per cycle
// through a single multiplier. A rejected set-bound word goes straight from
// accept to the output register. A new word is accepted while the previous
// result still waits in the output register.
module tensor_slice_address_generator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tsag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsag_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tsag_in_if.sink                         in_i,
  tsag_out_if.source                      out_o
);
  import tsag_pkg::*;

  ctrl_t   ctrl;
  dp_sts_t sts;

  tsag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .ctrl_o      (ctrl)
  );

  tsag_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_i.data),
    .ctrl_i      (ctrl),
    .sts_o       (sts),
    .out_data_o  (out_o.data)
  );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for tensor_slice_address_generator_core. A shadow
// of the slice walker predicts every result word from the accepted input
// words and the shape registers. Directed tests cover reset values, walk
// order, the field and size limits and shape changes during a walk. They
// are followed by a back-pressure test and a long random run with idles on
// both channels.
// ----------------------------------------------------------------------------
module tb;
  import tsag_pkg::*;

  localparam int unsigned                 RANDOM_WORDS   = 1500;
  localparam int unsigned                 DRAIN_CYCLES   = 12;
  localparam int unsigned                 TIMEOUT_CYCLES = 400000;
  localparam logic [CFG_IDX_W-1:0]        REG_UNUSED     = 3'd7;
  localparam logic [IDX_W-1:0]            IDX_MAX        = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tsag_in_if  cmd_ch ();
  tsag_out_if res_ch ();

  tensor_slice_address_generator_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (cmd_ch),
    .out_o       (res_ch)
  );

  // Shadow of the shape registers and the walker state.
  logic [RANK_W-1:0] shape_rank;
  logic [SIZE_W-1:0] shape_size [MAX_DIMS];
  logic [IDX_W-1:0]  lo_bound   [MAX_DIMS];
  logic [IDX_W-1:0]  hi_bound   [MAX_DIMS];
  logic [IDX_W-1:0]  walk_pos   [MAX_DIMS];
  logic [ADDR_W-1:0] walk_stride[MAX_DIMS];
  bit                walk_active;

  out_word_t   pending_results[$];
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned errors;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned sink_hold;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int active_dims();
    return (shape_rank > MAX_DIMS) ? MAX_DIMS : int'(shape_rank);
  endfunction

  function automatic bit is_wrapped(int k);
    return lo_bound[k] > hi_bound[k];
  endfunction

  function automatic logic [IDX_W-1:0] walk_first(int k);
    return is_wrapped(k) ? '0 : lo_bound[k];
  endfunction

  function automatic bit walk_at_end(int k);
    if (is_wrapped(k)) return int'(walk_pos[k]) + 1 >= int'(shape_size[k]);
    return walk_pos[k] >= hi_bound[k];
  endfunction

  function automatic logic [IDX_W-1:0] walk_succ(int k);
    if (is_wrapped(k) && walk_pos[k] == hi_bound[k]) return lo_bound[k];
    return walk_pos[k] + 1'b1;
  endfunction

  function automatic out_word_t walk_step(in_word_t w);
    out_word_t         r;
    int                rk;
    int                d;
    int                sz;
    int                s;
    int                e;
    int                len;
    bit                bad;
    bit                moved;
    bit                all_end;
    logic [ADDR_W-1:0] stride;
    r  = '0;
    rk = active_dims();
    d  = int'(w.dim_select);
    if (w.cmd == CMD_SET_BOUND) begin
      if (d >= rk) begin
        r.status = ST_BAD_DIM;
      end else begin
        sz = int'(shape_size[d]);
        s  = int'(w.range_start);
        e  = int'(w.range_end);
        if (s <= e) begin
          bad = e >= sz;
          len = e - s + 1;
        end else begin
          bad = s >= sz;
          len = bad ? 0 : e + 1 + (sz - s);
        end
        if (bad) begin
          r.status = ST_OUT_OF_RANGE;
        end else begin
          stride = 1;
          for (int k = 0; k < d; k++) stride = stride * shape_size[k];
          lo_bound[d]    = w.range_start;
          hi_bound[d]    = w.range_end;
          walk_stride[d] = stride;
          walk_active    = 1'b0;
          r.slice_length = len[LEN_W-1:0];
        end
      end
    end else begin
      if (!walk_active) begin
        for (int k = 0; k < rk; k++) walk_pos[k] = walk_first(k);
        walk_active = 1'b1;
      end else begin
        moved = 1'b0;
        for (int k = 0; k < rk; k++) begin
          if (!moved) begin
            if (!walk_at_end(k)) begin
              walk_pos[k] = walk_succ(k);
              moved = 1'b1;
            end else begin
              walk_pos[k] = walk_first(k);
            end
          end
        end
      end
      all_end = 1'b1;
      for (int k = 0; k < rk; k++) begin
        r.source_index = r.source_index + walk_pos[k] * walk_stride[k];
        if (!walk_at_end(k)) all_end = 1'b0;
      end
      if (all_end) begin
        r.last_element = 1'b1;
        walk_active = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic void queue_expected(out_word_t w);
    pending_results.insert(pending_results.size(), w);
  endfunction

  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        words_checked++;
        got = res_ch.data;
        if (pending_results.size() == 0) begin
          $error("result word with nothing pending: source_index %0d", got.source_index);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.source_index !== want.source_index) begin
            $error("source_index: expected %0d, got %0d", want.source_index, got.source_index);
            errors++;
          end
          if (got.slice_length !== want.slice_length) begin
            $error("slice_length: expected %0d, got %0d", want.slice_length, got.slice_length);
            errors++;
          end
          if (got.last_element !== want.last_element) begin
            $error("last_element: expected %0d, got %0d", want.last_element, got.last_element);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) queue_expected(walk_step(cmd_ch.data));
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold != 0) begin
        res_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= w;
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    words_sent++;
  endtask

  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (words_checked != words_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_RANK:      shape_rank = val[RANK_W-1:0];
      REG_SIZE_DIM0,
      REG_SIZE_DIM1,
      REG_SIZE_DIM2,
      REG_SIZE_DIM3: shape_size[DIM_W'(idx - REG_SIZE_DIM0)] = val;
      default: ;
    endcase
  endtask

  task automatic load_shape(input logic [RANK_W-1:0] rk, input logic [SIZE_W-1:0] s0,
                            input logic [SIZE_W-1:0] s1, input logic [SIZE_W-1:0] s2,
                            input logic [SIZE_W-1:0] s3);
    logic [CFG_DATA_W-1:0] rank_word;
    wait_idle();
    rank_word = CFG_DATA_W'($urandom);
    rank_word[RANK_W-1:0] = rk;
    write_reg(REG_RANK, rank_word);
    write_reg(REG_SIZE_DIM0, s0);
    write_reg(REG_SIZE_DIM1, s1);
    write_reg(REG_SIZE_DIM2, s2);
    write_reg(REG_SIZE_DIM3, s3);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_word_t bound_word(int d, int s, int e);
    in_word_t w;
    w.cmd         = CMD_SET_BOUND;
    w.dim_select  = d[DIM_W-1:0];
    w.range_start = s[IDX_W-1:0];
    w.range_end   = e[IDX_W-1:0];
    return w;
  endfunction

  function automatic in_word_t next_word();
    in_word_t w;
    w = in_word_t'($urandom);
    w.cmd = CMD_NEXT;
    return w;
  endfunction

  function automatic in_word_t random_bound(int d);
    int sz;
    int cap;
    int s;
    int e;
    sz = int'(shape_size[d]);
    if (sz == 0) return bound_word(d, $urandom_range(IDX_MAX), $urandom_range(IDX_MAX));
    cap = (sz > 1024) ? 1023 : sz - 1;
    if (cap >= 1 && $urandom_range(99) < 40) begin
      s = $urandom_range(cap, 1);
      e = $urandom_range(s - 1, 0);
    end else begin
      s = $urandom_range(cap, 0);
      e = $urandom_range(cap, s);
    end
    return bound_word(d, s, e);
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return SIZE_W'($urandom_range(4, 1));
    if (r < 88) return SIZE_W'($urandom_range(16, 1));
    if (r < 95) return SIZE_W'($urandom_range(1024, 17));
    if (r < 98) return SIZE_W'($urandom_range(2047, 1025));
    return '0;
  endfunction

  task automatic test_reset_values();
    send_word(bound_word(1, 0, 0));
    send_word(bound_word(0, 0, 1));
    send_word(bound_word(0, 1, 0));
    send_word(bound_word(0, 0, 0));
    send_word(next_word());
  endtask

  task automatic test_walk_order();
    load_shape(4, 2, 2, 3, 2);
    send_word(bound_word(0, 1, 1));
    send_word(bound_word(1, 1, 0));
    send_word(bound_word(2, 2, 0));
    send_word(bound_word(3, 1, 1));
    repeat (5) send_word(next_word());
  endtask

  task automatic test_limits();
    load_shape(7, 1024, 1024, 1024, 1024);
    send_word(bound_word(0, 0, 1023));
    send_word(bound_word(1, 1023, 0));
    repeat (2) send_word(next_word());
    load_shape(4, 2047, 2047, 2047, 2047);
    for (int d = 0; d < MAX_DIMS; d++) send_word(bound_word(d, 1023, 1023));
    send_word(next_word());
    load_shape(4, 1000, 0, 1, 1);
    send_word(bound_word(0, 0, 1000));
    send_word(bound_word(1, 0, 0));
    wait_idle();
    write_reg(REG_UNUSED, '1);
    cfg_we_i <= 1'b0;
    load_shape(0, 5, 5, 5, 5);
    send_word(next_word());
    send_word(bound_word(0, 0, 0));
  endtask

  task automatic test_shape_change();
    load_shape(1, 8, 1, 1, 1);
    send_word(bound_word(0, 6, 2));
    repeat (3) send_word(next_word());
    load_shape(1, 5, 1, 1, 1);
    repeat (2) send_word(next_word());
    load_shape(1, 2, 1, 1, 1);
    send_word(next_word());
  endtask

  task automatic test_backpressure();
    load_shape(3, 3, 4, 2, 1);
    for (int d = 0; d < 3; d++) send_word(random_bound(d));
    wait_idle();
    src_idle_pct = 0;
    sink_hold    = 300;
    repeat (40) send_word(next_word());
    wait_idle();
    src_idle_pct = 14;
  endtask

  task automatic test_random();
    int unsigned      base;
    int unsigned      n;
    int unsigned      r;
    logic [RANK_W-1:0] rk;
    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      if (words_sent - base >= 500 && words_sent - base < 800) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = 14;
        sink_idle_pct = 14;
      end
      if ($urandom_range(99) < 30) begin
        r  = $urandom_range(99);
        rk = (r < 3) ? 3'd0 : (r < 8) ? RANK_W'($urandom_range(7, 5)) :
             RANK_W'($urandom_range(4, 1));
        load_shape(rk, random_size(), random_size(), random_size(), random_size());
      end
      for (int d = 0; d < MAX_DIMS; d++)
        if ($urandom_range(2) != 0) send_word(random_bound(d));
      n = $urandom_range(40, 4);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 88) send_word(next_word());
        else if (r < 94) send_word(random_bound($urandom_range(MAX_DIMS - 1)));
        else send_word(in_word_t'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.data   = '0;
    shape_rank    = 1;
    walk_active   = 1'b0;
    words_sent    = 0;
    words_checked = 0;
    errors        = 0;
    src_idle_pct  = 14;
    sink_idle_pct = 14;
    sink_hold     = 0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      shape_size[k]  = 1;
      lo_bound[k]    = '0;
      hi_bound[k]    = '0;
      walk_pos[k]    = '0;
      walk_stride[k] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_walk_order();
    test_limits();
    test_shape_change();
    test_backpressure();
    test_random();
    wait_idle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
